@@ rtl/thread_queue_scheduler_core_macros.svh @@
// Assertion macros for the scheduler RTL.
`ifndef THREAD_QUEUE_SCHEDULER_CORE_MACROS_SVH
`define THREAD_QUEUE_SCHEDULER_CORE_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define TQS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define TQS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/tqs_pkg.sv @@
// Types and codes shared by the thread queue scheduler.
package tqs_pkg;

   typedef logic [2:0] tqs_func_type;
   typedef logic [1:0] tqs_status_type;
   typedef logic [2:0] tqs_list_type;

   localparam tqs_func_type FN_ENTER   = 3'd0;
   localparam tqs_func_type FN_READY   = 3'd1;
   localparam tqs_func_type FN_IDLE    = 3'd2;
   localparam tqs_func_type FN_EXIT    = 3'd3;
   localparam tqs_func_type FN_CLEAN   = 3'd4;
   localparam tqs_func_type FN_DESCHED = 3'd5;
   localparam tqs_func_type FN_SCHED   = 3'd6;
   localparam tqs_func_type FN_RESCHED = 3'd7;

   localparam tqs_status_type ST_OK      = 2'd0;
   localparam tqs_status_type ST_BAD     = 2'd1;
   localparam tqs_status_type ST_NOFREE  = 2'd2;
   localparam tqs_status_type ST_NOTHING = 2'd3;

   localparam tqs_list_type LST_NONE  = 3'd0;
   localparam tqs_list_type LST_ENTER = 3'd1;
   localparam tqs_list_type LST_READY = 3'd2;
   localparam tqs_list_type LST_STALL = 3'd3;
   localparam tqs_list_type LST_IDLE  = 3'd4;
   localparam tqs_list_type LST_RUN   = 3'd5;
   localparam tqs_list_type LST_EXIT  = 3'd6;

   localparam int NUM_LISTS = 6;

   localparam logic [1:0] TSTAT_NORMAL  = 2'd0;
   localparam logic [1:0] TSTAT_STALLED = 2'd1;
   localparam logic [1:0] TSTAT_EXITING = 2'd2;

   typedef struct packed {
      tqs_func_type func;
      logic [5:0]   slot;
      logic [15:0]  proc_in;
      logic [15:0]  thread_in;
      logic [1:0]   thread_status;
   } tqs_req_type;

   typedef struct packed {
      tqs_status_type status;
      logic [5:0]     slot_out;
      logic [15:0]    proc_out;
      logic [15:0]    thread_out;
   } tqs_rsp_type;

   typedef struct packed {
      tqs_list_type list;
      logic         exit_pending;
   } tqs_meta_type;

   // Position of a list in the head, tail and count registers.
   function automatic logic [2:0] list_idx(tqs_list_type l);
      return l - 3'd1;
   endfunction

   // Builds a response; the slot and id fields are zero unless reported.
   function automatic tqs_rsp_type make_rsp(tqs_status_type st, logic report,
                                            logic [5:0] s, logic [15:0] p,
                                            logic [15:0] t);
      tqs_rsp_type r;
      r.status     = st;
      r.slot_out   = report ? s : 6'd0;
      r.proc_out   = report ? p : 16'd0;
      r.thread_out = report ? t : 16'd0;
      return r;
   endfunction

endpackage

@@ rtl/tqs_ram.sv @@
// Simple dual-port synchronous memory with a registered read port.
module tqs_ram
   import tqs_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tqs_free_map.sv @@
// Free-slot bitmap with a chunked lowest-free search.
module tqs_free_map
   import tqs_pkg::*;
#(
   parameter int NUM_SLOTS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         search_en,
   output logic                         hit,
   output logic                         last,
   output logic [$clog2(NUM_SLOTS)-1:0] hit_slot,
   input  logic                         clr_en,
   input  logic [$clog2(NUM_SLOTS)-1:0] clr_idx,
   input  logic                         set_en,
   input  logic [$clog2(NUM_SLOTS)-1:0] set_idx,
   input  logic [$clog2(NUM_SLOTS)-1:0] rd_idx,
   output logic                         rd_free
);

   localparam int SW   = $clog2(NUM_SLOTS);
   localparam int CW   = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;
   localparam int NCH  = (NUM_SLOTS + CW - 1) / CW;
   localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;

   logic [NUM_SLOTS-1:0] free_ff, free_in;
   logic [CHW-1:0]       chunk_ff, chunk_in;
   logic [NCH*CW-1:0]    free_pad;
   logic [CW-1:0]        chunk_bits;
   int                   pos;

   assign free_pad   = (NCH*CW)'(free_ff);
   assign chunk_bits = free_pad[int'(chunk_ff)*CW +: CW];

   // Lowest set bit of the current chunk.
   always_comb begin
      pos = 0;
      hit = 1'b0;
      for (int j = CW - 1; j >= 0; j--) begin
         if (chunk_bits[j]) begin
            pos = j;
            hit = 1'b1;
         end
      end
   end

   assign hit_slot = SW'(int'(chunk_ff) * CW + pos);
   assign last     = (int'(chunk_ff) == NCH - 1);
   assign rd_free  = free_ff[rd_idx];

   always_comb begin
      free_in = free_ff;
      if (clr_en) begin
         free_in[clr_idx] = 1'b0;
      end
      if (set_en) begin
         free_in[set_idx] = 1'b1;
      end
      chunk_in = (search_en && !last) ? chunk_ff + 1'b1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= '1;
         chunk_ff <= '0;
      end else begin
         free_ff  <= free_in;
         chunk_ff <= chunk_in;
      end
   end

endmodule

@@ rtl/thread_queue_scheduler_core.sv @@
// Top level of the thread queue scheduler: sequencer over the slot memories.
//
//   Channel   Ports                        Direction   Handshake
//   request   start, busy, req_payload     in          taken when start && !busy
//   response  rsp_strobe, rsp_payload      out         one-cycle strobe, no stall
//
// A transaction keeps busy high through the dependent read-modify-write
// passes on the link memories: lookup, unlink, push; sched is a head pick
// followed by those three, and resched runs the desched passes and then the
// sched passes.
// Enter scans the free map in chunks of up to 32 slots before its push.
// The response strobe comes in the cycle after the transaction's last step.
// Reset is synchronous; the free map marks every slot free, all list heads,
// tails and counts clear at once, and the slot memories need no clearing pass.
// The receiver cannot stall, so busy depends only on the sequencer.
module thread_queue_scheduler_core
   import tqs_pkg::*;
#(
   parameter int NUM_SLOTS = 64,
   parameter int ID_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  tqs_req_type req_payload,
   output logic        rsp_strobe,
   output tqs_rsp_type rsp_payload
);

`include "thread_queue_scheduler_core_macros.svh"

   localparam int SW   = $clog2(NUM_SLOTS);
   localparam int XW   = (SW > 6) ? SW : 6;
   localparam int IXW  = (ID_BITS > 16) ? ID_BITS : 16;
   localparam int CNTW = $clog2(NUM_SLOTS + 1);

   // One-hot sequencer states.
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_FIND   = 6'b000010,
      S_LOOK   = 6'b000100,
      S_UNLINK = 6'b001000,
      S_PUSH   = 6'b010000,
      S_PICK   = 6'b100000
   } tqs_state_type;

   tqs_state_type      state_ff, state_in;
   tqs_func_type       func_ff, func_in;
   logic [1:0]         tstat_ff, tstat_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [ID_BITS-1:0] proc_ff, proc_in;
   logic [ID_BITS-1:0] thread_ff, thread_in;
   logic               sched_ff, sched_in;
   tqs_list_type       cur_ff, cur_in;
   tqs_list_type       dst_ff, dst_in;
   logic               ep_ff, ep_in;
   logic [SW-1:0]      head_ff [NUM_LISTS];
   logic [SW-1:0]      head_in [NUM_LISTS];
   logic [SW-1:0]      tail_ff [NUM_LISTS];
   logic [SW-1:0]      tail_in [NUM_LISTS];
   logic [CNTW-1:0]    cnt_ff  [NUM_LISTS];
   logic [CNTW-1:0]    cnt_in  [NUM_LISTS];
   logic               rsp_strobe_ff, rsp_strobe_in;
   tqs_rsp_type        rsp_ff, rsp_in;

   // Memory ports.
   logic                 rd_en;
   logic [SW-1:0]        rd_addr;
   logic                 meta_we, next_we, prev_we, id_we;
   logic [SW-1:0]        meta_wa, next_wa, prev_wa;
   tqs_meta_type         meta_wd, meta_rd;
   logic [SW-1:0]        next_wd, prev_wd, next_rd, prev_rd;
   logic [2*ID_BITS-1:0] id_wd, id_rd;

   // Free map ports.
   logic          search_en, hit, last, rd_free, clr_en, set_en;
   logic [SW-1:0] hit_slot;

   // Width conversions of the fixed-width fields.
   logic [XW-1:0]      req_slot_x, slot_x;
   logic [SW-1:0]      req_slot;
   logic [IXW-1:0]     req_proc_x, req_thread_x;
   logic [IXW-1:0]     out_proc_x, out_thread_x, in_proc_x, in_thread_x;
   logic               req_oob;

   assign req_slot_x   = XW'(req_payload.slot);
   assign req_slot     = req_slot_x[SW-1:0];
   assign req_oob      = (int'(req_payload.slot) >= NUM_SLOTS);
   assign req_proc_x   = IXW'(req_payload.proc_in);
   assign req_thread_x = IXW'(req_payload.thread_in);
   assign slot_x       = XW'(slot_ff);
   assign out_proc_x   = IXW'(id_rd[2*ID_BITS-1:ID_BITS]);
   assign out_thread_x = IXW'(id_rd[ID_BITS-1:0]);
   assign in_proc_x    = IXW'(proc_ff);
   assign in_thread_x  = IXW'(thread_ff);

   tqs_ram #(.DEPTH(NUM_SLOTS), .WIDTH($bits(tqs_meta_type))) u_meta (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(meta_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(meta_rd)
   );

   tqs_ram #(.DEPTH(NUM_SLOTS), .WIDTH(SW)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(next_rd)
   );

   tqs_ram #(.DEPTH(NUM_SLOTS), .WIDTH(SW)) u_prev (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(prev_rd)
   );

   tqs_ram #(.DEPTH(NUM_SLOTS), .WIDTH(2*ID_BITS)) u_ids (
      .clock(clock), .wr_en(id_we), .wr_addr(slot_in), .wr_data(id_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(id_rd)
   );

   tqs_free_map #(.NUM_SLOTS(NUM_SLOTS)) u_free (
      .clock(clock), .reset(reset), .search_en(search_en), .hit(hit),
      .last(last), .hit_slot(hit_slot), .clr_en(clr_en), .clr_idx(hit_slot),
      .set_en(set_en), .set_idx(slot_ff), .rd_idx(slot_ff), .rd_free(rd_free)
   );

   assign search_en = (state_ff == S_FIND);

   always_comb begin
      tqs_list_type  cur;
      tqs_list_type  pick;
      logic [2:0]    ci;
      logic [2:0]    di;
      logic          accept;

      state_in      = state_ff;
      func_in       = func_ff;
      tstat_in      = tstat_ff;
      slot_in       = slot_ff;
      proc_in       = proc_ff;
      thread_in     = thread_ff;
      sched_in      = sched_ff;
      cur_in        = cur_ff;
      dst_in        = dst_ff;
      ep_in         = ep_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = slot_ff;
      meta_we       = 1'b0;
      meta_wa       = slot_ff;
      meta_wd       = '{list: dst_ff, exit_pending: ep_ff};
      next_we       = 1'b0;
      next_wa       = prev_rd;
      next_wd       = next_rd;
      prev_we       = 1'b0;
      prev_wa       = next_rd;
      prev_wd       = prev_rd;
      id_we         = 1'b0;
      id_wd         = {proc_ff, thread_ff};
      clr_en        = 1'b0;
      set_en        = 1'b0;
      cur           = rd_free ? LST_NONE : meta_rd.list;
      pick          = LST_READY;
      ci            = list_idx(cur_ff);
      di            = list_idx(dst_ff);
      accept        = start && (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in   = req_payload.func;
               tstat_in  = req_payload.thread_status;
               proc_in   = req_proc_x[ID_BITS-1:0];
               thread_in = req_thread_x[ID_BITS-1:0];
               slot_in   = req_slot;
               sched_in  = 1'b0;
               if (req_payload.func == FN_ENTER) begin
                  state_in = S_FIND;
               end else if (req_payload.func == FN_SCHED) begin
                  state_in = S_PICK;
               end else if (req_oob) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = make_rsp(ST_BAD, 1'b0, 6'd0, 16'd0, 16'd0);
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = req_slot;
                  state_in = S_LOOK;
               end
            end
         end

         S_FIND: begin
            if (hit) begin
               slot_in  = hit_slot;
               clr_en   = 1'b1;
               id_we    = 1'b1;
               dst_in   = LST_ENTER;
               ep_in    = 1'b0;
               state_in = S_PUSH;
            end else if (last) begin
               rsp_strobe_in = 1'b1;
               rsp_in   = make_rsp(ST_NOFREE, 1'b0, 6'd0, 16'd0, 16'd0);
               state_in = S_IDLE;
            end
         end

         S_PICK: begin
            // The ready list goes first, then the idle list.
            if (cnt_ff[list_idx(LST_READY)] != '0) begin
               pick = LST_READY;
            end else begin
               pick = LST_IDLE;
            end
            if (cnt_ff[list_idx(pick)] != '0) begin
               slot_in  = head_ff[list_idx(pick)];
               rd_en    = 1'b1;
               rd_addr  = head_ff[list_idx(pick)];
               sched_in = 1'b1;
               state_in = S_LOOK;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_in   = make_rsp(ST_NOTHING, 1'b0, 6'd0, 16'd0, 16'd0);
               state_in = S_IDLE;
            end
         end

         S_LOOK: begin
            cur_in   = cur;
            ep_in    = 1'b0;
            state_in = S_UNLINK;
            if (sched_ff) begin
               dst_in = LST_RUN;
               ep_in  = meta_rd.exit_pending;
            end else begin
               unique case (func_ff)
                  FN_READY: begin
                     if (cur == LST_ENTER || cur == LST_STALL) begin
                        dst_in = LST_READY;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
                  FN_IDLE: begin
                     if (cur == LST_ENTER) begin
                        dst_in = LST_IDLE;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
                  FN_EXIT: begin
                     // A running thread only gets the pending mark.
                     if (cur == LST_RUN) begin
                        meta_we  = 1'b1;
                        meta_wd  = '{list: LST_RUN, exit_pending: 1'b1};
                        state_in = S_IDLE;
                     end else if (cur == LST_EXIT || cur == LST_NONE) begin
                        state_in = S_IDLE;
                     end else begin
                        dst_in = LST_EXIT;
                     end
                  end
                  FN_CLEAN: begin
                     if (cur == LST_EXIT) begin
                        dst_in = LST_NONE;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
                  FN_DESCHED, FN_RESCHED: begin
                     if (cur != LST_RUN || tstat_ff == 2'd3) begin
                        state_in = S_IDLE;
                     end else if (meta_rd.exit_pending
                                  || tstat_ff == TSTAT_EXITING) begin
                        dst_in = LST_EXIT;
                     end else if (tstat_ff == TSTAT_STALLED) begin
                        dst_in = LST_STALL;
                     end else begin
                        dst_in = LST_READY;
                     end
                  end
                  FN_ENTER, FN_SCHED: begin
                     state_in = S_IDLE;
                  end
               endcase
               if (state_in == S_IDLE) begin
                  rsp_strobe_in = 1'b1;
                  if (func_ff == FN_EXIT && cur != LST_NONE) begin
                     rsp_in = make_rsp(ST_OK, 1'b0, 6'd0, 16'd0, 16'd0);
                  end else begin
                     rsp_in = make_rsp(ST_BAD, 1'b0, 6'd0, 16'd0, 16'd0);
                  end
               end
            end
         end

         S_UNLINK: begin
            // Head and tail links of a list are never followed, so only the
            // middle case touches the link memories.
            if (cnt_ff[ci] <= CNTW'(1)) begin
               head_in[ci] = '0;
               tail_in[ci] = '0;
            end else if (head_ff[ci] == slot_ff) begin
               head_in[ci] = next_rd;
            end else if (tail_ff[ci] == slot_ff) begin
               tail_in[ci] = prev_rd;
            end else begin
               next_we = 1'b1;
               prev_we = 1'b1;
            end
            cnt_in[ci] = cnt_ff[ci] - 1'b1;
            if (dst_ff == LST_NONE) begin
               set_en        = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_in   = make_rsp(ST_OK, 1'b0, 6'd0, 16'd0, 16'd0);
               state_in = S_IDLE;
            end else begin
               state_in = S_PUSH;
            end
         end

         S_PUSH: begin
            meta_we = 1'b1;
            if (cnt_ff[di] != '0) begin
               next_we = 1'b1;
               next_wa = tail_ff[di];
               next_wd = slot_ff;
               prev_we = 1'b1;
               prev_wa = slot_ff;
               prev_wd = tail_ff[di];
            end else begin
               head_in[di] = slot_ff;
            end
            tail_in[di] = slot_ff;
            cnt_in[di]  = cnt_ff[di] + 1'b1;
            if (func_ff == FN_RESCHED && !sched_ff) begin
               state_in = S_PICK;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (sched_ff) begin
                  rsp_in = make_rsp(ST_OK, 1'b1, slot_x[5:0], out_proc_x[15:0],
                                    out_thread_x[15:0]);
               end else if (func_ff == FN_ENTER) begin
                  rsp_in = make_rsp(ST_OK, 1'b1, slot_x[5:0], in_proc_x[15:0],
                                    in_thread_x[15:0]);
               end else begin
                  rsp_in = make_rsp(ST_OK, 1'b0, 6'd0, 16'd0, 16'd0);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Transaction payload and working registers need no reset.
   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      tstat_ff  <= tstat_in;
      slot_ff   <= slot_in;
      proc_ff   <= proc_in;
      thread_ff <= thread_in;
      sched_ff  <= sched_in;
      cur_ff    <= cur_in;
      dst_ff    <= dst_in;
      ep_ff     <= ep_in;
      rsp_ff    <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // Every accepted transaction either keeps the sequencer busy or answers.
   `TQS_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe, "accepted transaction neither started nor answered")
   // A response is only shown once the sequencer has returned to idle.
   `TQS_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_strobe, !busy, "response strobe while sequencer busy")
   // Unlinking always takes a slot out of a list that holds it.
   `TQS_ASSERT_NOW(a_unlink_nonempty, clock, reset, state_ff == S_UNLINK, cnt_ff[list_idx(cur_ff)] != '0, "unlink from an empty list")
   // A push always targets a real list.
   `TQS_ASSERT_NOW(a_push_target, clock, reset, state_ff == S_PUSH, dst_ff != LST_NONE, "push without a target list")

endmodule
